### hw/rtl/rht_pkg.sv
// Package for the reference-counted handle table.
// Holds default sizes, command and status codes, and the item classification.
// No dependencies.
package rht_pkg;

   localparam int RHT_SLOTS         = 16;
   localparam int RHT_HANDLE_WIDTH  = 32;
   localparam int RHT_PAYLOAD_WIDTH = 32;
   localparam int RHT_REF_WIDTH     = 16;

   localparam int FIELD_WIDTH = 32;
   localparam int LIVE_WIDTH  = 5;

   typedef enum logic [1:0] {
      CMD_NEW     = 2'd0,
      CMD_GRAB    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_ZERO_PAYLOAD = 3'd1,
      ST_FULL         = 3'd2,
      ST_NO_HANDLE    = 3'd3,
      ST_STILL_REF    = 3'd4,
      ST_SATURATED    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      K_NEW     = 3'd0,
      K_GRAB    = 3'd1,
      K_RELEASE = 3'd2,
      K_ZERO_PL = 3'd3,
      K_BAD     = 3'd4
   } kind_type;

   localparam int KIND_WIDTH = 3;

endpackage

### hw/rtl/rht_front.sv
// Front end of the handle table: accepts request transactions, classifies them
// and computes the slot index of the handle. Depends on rht_pkg.
module rht_front #(
   parameter int SLOTS         = rht_pkg::RHT_SLOTS,
   parameter int PAYLOAD_WIDTH = rht_pkg::RHT_PAYLOAD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [1:0]                   req_cmd,
   input  logic [31:0]                  req_handle,
   input  logic [31:0]                  req_payload,
   input  logic                         clearing,
   input  logic                         q_full,
   output logic                         q_push,
   output rht_pkg::kind_type            q_kind,
   output logic [$clog2(SLOTS)-1:0]     q_slot,
   output logic [31:0]                  q_handle,
   output logic [PAYLOAD_WIDTH-1:0]     q_payload
);
   import rht_pkg::*;

   localparam int SW   = $clog2(SLOTS);
   localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
   localparam int PEXT = (PAYLOAD_WIDTH > FIELD_WIDTH) ? PAYLOAD_WIDTH : FIELD_WIDTH;

   logic [1:0]               cmd_sel;
   logic [31:0]              handle_sel;
   logic [31:0]              payload_sel;
   logic [PEXT-1:0]          payload_ext;
   logic [PAYLOAD_WIDTH-1:0] payload_kept;

   assign payload_ext  = PEXT'(payload_sel);
   assign payload_kept = payload_ext[PAYLOAD_WIDTH-1:0];
   assign q_handle     = handle_sel;
   assign q_payload    = payload_kept;

   always_comb begin
      unique case (cmd_type'(cmd_sel))
         CMD_NEW:     q_kind = (payload_kept == '0) ? K_ZERO_PL : K_NEW;
         CMD_GRAB:    q_kind = (handle_sel == '0) ? K_BAD : K_GRAB;
         CMD_RELEASE: q_kind = (handle_sel == '0) ? K_BAD : K_RELEASE;
         default:     q_kind = K_BAD;
      endcase
   end

   generate
      if (POW2) begin : g_mask
         assign cmd_sel     = req_cmd;
         assign handle_sel  = req_handle;
         assign payload_sel = req_payload;
         assign q_slot      = req_handle[SW-1:0];
         assign full        = q_full || clearing;
         assign q_push      = push && !full;
      end else begin : g_recip
         // The slot is the handle modulo SLOTS. The quotient comes from a
         // multiplication by the rounded-up reciprocal, split into two
         // partial products, and the remainder from its low bits.
         typedef enum logic [3:0] {
            F_IDLE = 4'b0001,
            F_MUL  = 4'b0010,
            F_FOLD = 4'b0100,
            F_PUSH = 4'b1000
         } fstate_type;

         localparam logic [63:0] RECIP =
            ((64'd1 << (32 + SW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
         localparam logic [15:0] RECIP_LO = RECIP[15:0];
         localparam logic [16:0] RECIP_HI = RECIP[32:16];

         fstate_type state_ff, state_in;
         logic [47:0]   lo_ff;
         logic [48:0]   hi_ff;
         logic [64:0]   prod_sum;
         logic [SW-1:0] quot_lo;
         logic [SW-1:0] rem_ff, rem_in;
         logic [1:0]    cmd_ff;
         logic [31:0]   handle_ff;
         logic [31:0]   payload_ff;
         logic          take;

         assign cmd_sel     = cmd_ff;
         assign handle_sel  = handle_ff;
         assign payload_sel = payload_ff;
         assign q_slot      = rem_ff;
         assign full        = clearing || (state_ff != F_IDLE);
         assign take        = push && !full;
         assign q_push      = (state_ff == F_PUSH) && !q_full;
         assign prod_sum    = {hi_ff, 16'b0} + 65'(lo_ff);
         assign quot_lo     = prod_sum[32+SW +: SW];
         assign rem_in      = handle_ff[SW-1:0] - SW'(quot_lo * SW'(SLOTS));

         always_comb begin
            state_in = state_ff;
            unique case (state_ff)
               F_IDLE: begin
                  if (take) begin
                     state_in = F_MUL;
                  end
               end
               F_MUL:  state_in = F_FOLD;
               F_FOLD: state_in = F_PUSH;
               F_PUSH: begin
                  if (!q_full) begin
                     state_in = F_IDLE;
                  end
               end
               default: state_in = F_IDLE;
            endcase
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               state_ff <= F_IDLE;
            end else begin
               state_ff <= state_in;
            end
         end

         always_ff @(posedge clock) begin
            if (take) begin
               cmd_ff     <= req_cmd;
               handle_ff  <= req_handle;
               payload_ff <= req_payload;
            end
            if (state_ff == F_MUL) begin
               lo_ff <= 48'(handle_ff) * 48'(RECIP_LO);
               hi_ff <= 49'(handle_ff) * 49'(RECIP_HI);
            end
            if (state_ff == F_FOLD) begin
               rem_ff <= rem_in;
            end
         end
      end
   endgenerate

endmodule

### hw/rtl/rht_queue.sv
// Two-entry queue that decouples the front end from the execution back end.
// No dependencies.
module rht_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic                  q_full,
   input  logic                  rd_en,
   output logic [DATA_WIDTH-1:0] rd_data,
   output logic                  q_empty
);

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_wr, do_rd;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hw/rtl/rht_back.sv
// Back end of the handle table: holds the slot memories, carries out new, grab
// and release, and drives the result register. Depends on rht_pkg.
module rht_back #(
   parameter int SLOTS         = rht_pkg::RHT_SLOTS,
   parameter int HANDLE_WIDTH  = rht_pkg::RHT_HANDLE_WIDTH,
   parameter int PAYLOAD_WIDTH = rht_pkg::RHT_PAYLOAD_WIDTH,
   parameter int REF_WIDTH     = rht_pkg::RHT_REF_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  rht_pkg::kind_type        q_kind,
   input  logic [$clog2(SLOTS)-1:0] q_slot,
   input  logic [31:0]              q_handle,
   input  logic [PAYLOAD_WIDTH-1:0] q_payload,
   output logic                     clearing,
   output logic                     empty,
   input  logic                     pop,
   output logic [31:0]              rsp_handle_out,
   output logic [31:0]              rsp_payload_out,
   output logic [2:0]               rsp_status,
   output logic [4:0]               rsp_live_count
);
   import rht_pkg::*;

   localparam int SW      = $clog2(SLOTS);
   localparam int OW      = $clog2(SLOTS + 1);
   localparam int FULL    = SLOTS * 3 / 4;
   localparam int TRY_MAX = 2 * SLOTS + 2;
   localparam int TW      = $clog2(TRY_MAX + 1);
   localparam int HEXT    = (HANDLE_WIDTH > FIELD_WIDTH) ? HANDLE_WIDTH : FIELD_WIDTH;
   localparam int PEXT    = (PAYLOAD_WIDTH > FIELD_WIDTH) ? PAYLOAD_WIDTH : FIELD_WIDTH;
   localparam int LEXT    = (OW > LIVE_WIDTH) ? OW : LIVE_WIDTH;

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] handle;
      logic [REF_WIDTH-1:0]    refs;
   } slot_type;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EVAL  = 3'b100
   } bstate_type;

   slot_type                 slot_mem [SLOTS];
   logic [PAYLOAD_WIDTH-1:0] pl_mem   [SLOTS];

   bstate_type               state_ff, state_in;
   logic [SW-1:0]            clr_ff, clr_in;
   logic [HANDLE_WIDTH-1:0]  last_ff, last_in;
   logic [SW-1:0]            lslot_ff, lslot_in;
   logic [TW-1:0]            tries_ff, tries_in;
   logic [OW-1:0]            occ_ff, occ_in;
   logic                     out_valid_ff, out_valid_in;
   logic [31:0]              rsp_h_ff, rsp_h_in;
   logic [31:0]              rsp_p_ff, rsp_p_in;
   status_type               rsp_s_ff, rsp_s_in;
   logic [OW-1:0]            rsp_l_ff, rsp_l_in;
   kind_type                 op_kind_ff;
   logic [SW-1:0]            op_slot_ff;
   logic [31:0]              op_handle_ff;
   logic [PAYLOAD_WIDTH-1:0] op_payload_ff;

   slot_type                 rd_ff;
   logic [PAYLOAD_WIDTH-1:0] prd_ff;
   logic [SW-1:0]            rd_addr;
   logic                     mem_we, pl_we;
   logic [SW-1:0]            mem_wa;
   slot_type                 mem_wd;

   logic                     out_free, emit;
   logic [HANDLE_WIDTH-1:0]  nxt, cand_h;
   logic [SW-1:0]            cand_s;
   logic                     match;
   logic [REF_WIDTH-1:0]     refs_dec;
   logic [HEXT-1:0]          last_ext;
   logic [PEXT-1:0]          prd_ext;
   logic [LEXT-1:0]          live_ext;

   assign clearing = (state_ff == S_CLEAR);
   assign out_free = !out_valid_ff || pop;
   assign last_ext = HEXT'(last_ff);
   assign prd_ext  = PEXT'(prd_ff);
   assign match    = HEXT'(rd_ff.handle) == HEXT'(op_handle_ff);
   assign refs_dec = (rd_ff.refs == '0) ? '0 : rd_ff.refs - REF_WIDTH'(1);

   always_comb begin
      nxt = last_ff + HANDLE_WIDTH'(1);
      if (nxt == '0) begin
         cand_h = HANDLE_WIDTH'(1);
         cand_s = SW'(1);
      end else begin
         cand_h = nxt;
         cand_s = (lslot_ff == SW'(SLOTS - 1)) ? '0 : lslot_ff + SW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      last_in      = last_ff;
      lslot_in     = lslot_ff;
      tries_in     = tries_ff;
      occ_in       = occ_ff;
      q_pop        = 1'b0;
      rd_addr      = op_slot_ff;
      mem_we       = 1'b0;
      pl_we        = 1'b0;
      mem_wa       = op_slot_ff;
      mem_wd       = rd_ff;
      emit         = 1'b0;
      rsp_h_in     = '0;
      rsp_p_in     = '0;
      rsp_s_in     = ST_OK;
      rsp_l_in     = occ_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               rd_addr = q_slot;
               unique case (q_kind)
                  K_ZERO_PL: begin
                     emit     = 1'b1;
                     rsp_s_in = ST_ZERO_PAYLOAD;
                  end
                  K_NEW: begin
                     if (occ_ff >= OW'(FULL)) begin
                        emit     = 1'b1;
                        rsp_s_in = ST_FULL;
                     end else begin
                        last_in  = cand_h;
                        lslot_in = cand_s;
                        tries_in = TW'(1);
                        rd_addr  = cand_s;
                        state_in = S_EVAL;
                     end
                  end
                  K_GRAB, K_RELEASE: begin
                     state_in = S_EVAL;
                  end
                  default: begin
                     emit     = 1'b1;
                     rsp_s_in = ST_NO_HANDLE;
                  end
               endcase
            end
         end
         S_EVAL: begin
            state_in = S_IDLE;
            unique case (op_kind_ff)
               K_NEW: begin
                  if (rd_ff.handle == '0) begin
                     mem_we      = 1'b1;
                     pl_we       = 1'b1;
                     mem_wa      = lslot_ff;
                     mem_wd      = '{handle: last_ff, refs: REF_WIDTH'(1)};
                     occ_in      = occ_ff + OW'(1);
                     emit        = 1'b1;
                     rsp_h_in    = last_ext[31:0];
                     rsp_l_in    = occ_in;
                  end else if (tries_ff == TW'(TRY_MAX)) begin
                     emit     = 1'b1;
                     rsp_s_in = ST_FULL;
                  end else begin
                     last_in  = cand_h;
                     lslot_in = cand_s;
                     tries_in = tries_ff + TW'(1);
                     rd_addr  = cand_s;
                     state_in = S_EVAL;
                  end
               end
               K_GRAB: begin
                  emit = 1'b1;
                  if (!match) begin
                     rsp_s_in = ST_NO_HANDLE;
                  end else if (rd_ff.refs == '1) begin
                     rsp_s_in = ST_SATURATED;
                     rsp_p_in = prd_ext[31:0];
                  end else begin
                     mem_we      = 1'b1;
                     mem_wd.refs = rd_ff.refs + REF_WIDTH'(1);
                     rsp_p_in    = prd_ext[31:0];
                  end
               end
               K_RELEASE: begin
                  emit = 1'b1;
                  if (!match) begin
                     rsp_s_in = ST_NO_HANDLE;
                  end else if (refs_dec == '0) begin
                     mem_we   = 1'b1;
                     mem_wd   = '0;
                     rsp_p_in = prd_ext[31:0];
                     occ_in   = (occ_ff == '0) ? '0 : occ_ff - OW'(1);
                     rsp_l_in = occ_in;
                  end else begin
                     mem_we      = 1'b1;
                     mem_wd.refs = refs_dec;
                     rsp_s_in    = ST_STILL_REF;
                  end
               end
               default: begin
                  emit     = 1'b1;
                  rsp_s_in = ST_NO_HANDLE;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = emit ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         last_ff      <= '0;
         lslot_ff     <= '0;
         tries_ff     <= '0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         lslot_ff     <= lslot_in;
         tries_ff     <= tries_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_kind_ff    <= q_kind;
         op_slot_ff    <= q_slot;
         op_handle_ff  <= q_handle;
         op_payload_ff <= q_payload;
      end
      if (emit) begin
         rsp_h_ff <= rsp_h_in;
         rsp_p_ff <= rsp_p_in;
         rsp_s_ff <= rsp_s_in;
         rsp_l_ff <= rsp_l_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (pl_we) begin
         pl_mem[mem_wa] <= op_payload_ff;
      end
      rd_ff  <= slot_mem[rd_addr];
      prd_ff <= pl_mem[rd_addr];
   end

   assign live_ext        = LEXT'(rsp_l_ff);
   assign empty           = !out_valid_ff;
   assign rsp_handle_out  = rsp_h_ff;
   assign rsp_payload_out = rsp_p_ff;
   assign rsp_status      = rsp_s_ff;
   assign rsp_live_count  = live_ext[4:0];

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(FULL))
      else $error("Occupied slot count exceeds the full mark.");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop && !emit)
      else $error("Transaction taken during the clearing pass.");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("Result written over a waiting result.");
   a_tries_bound: assert property (@(posedge clock) disable iff (reset)
      tries_ff <= TW'(TRY_MAX))
      else $error("Probe count exceeds its limit.");
`endif

endmodule

### hw/rtl/refcounted_handle_table.sv
// Reference-counted handle table: issues nonzero handles for payloads, counts
// references per handle and frees a slot when its count drops to zero. After
// reset a clearing pass over all slots runs, during which full stays high. A
// grab or release then passes the idle and evaluate states of the execution
// unit, set by the registered read and the write-back of the slot memory; a
// rejected request is answered in the idle state, and a new request stays in
// the evaluate state while it probes further slots. For a SLOTS that is not a
// power of two, the front end finds the slot of a handle by a reciprocal
// multiplication and takes no new request until the last is pushed. A two-entry
// queue lets requests be taken while the execution unit or result port is busy.
// Depends on rht_pkg, rht_front, rht_queue and rht_back.
module refcounted_handle_table #(
   parameter int SLOTS         = rht_pkg::RHT_SLOTS,
   parameter int HANDLE_WIDTH  = rht_pkg::RHT_HANDLE_WIDTH,
   parameter int PAYLOAD_WIDTH = rht_pkg::RHT_PAYLOAD_WIDTH,
   parameter int REF_WIDTH     = rht_pkg::RHT_REF_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_handle,
   input  logic [31:0] req_payload,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_handle_out,
   output logic [31:0] rsp_payload_out,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_live_count
);
   import rht_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int DW = KIND_WIDTH + SW + 32 + PAYLOAD_WIDTH;

   logic                     clearing;
   logic                     q_full, q_empty, q_push, q_pop;
   kind_type                 f_kind;
   logic [SW-1:0]            f_slot;
   logic [31:0]              f_handle;
   logic [PAYLOAD_WIDTH-1:0] f_payload;
   logic [DW-1:0]            q_din, q_dout;
   kind_type                 b_kind;
   logic [SW-1:0]            b_slot;
   logic [31:0]              b_handle;
   logic [PAYLOAD_WIDTH-1:0] b_payload;

   assign q_din = {f_kind, f_slot, f_handle, f_payload};
   assign {b_slot, b_handle, b_payload} = q_dout[DW-KIND_WIDTH-1:0];
   assign b_kind = kind_type'(q_dout[DW-1 -: KIND_WIDTH]);

   rht_front #(
      .SLOTS         (SLOTS),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_cmd     (req_cmd),
      .req_handle  (req_handle),
      .req_payload (req_payload),
      .clearing    (clearing),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_kind      (f_kind),
      .q_slot      (f_slot),
      .q_handle    (f_handle),
      .q_payload   (f_payload)
   );

   rht_queue #(
      .DATA_WIDTH (DW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_din),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_dout),
      .q_empty (q_empty)
   );

   rht_back #(
      .SLOTS         (SLOTS),
      .HANDLE_WIDTH  (HANDLE_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
      .REF_WIDTH     (REF_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_kind          (b_kind),
      .q_slot          (b_slot),
      .q_handle        (b_handle),
      .q_payload       (b_payload),
      .clearing        (clearing),
      .empty           (empty),
      .pop             (pop),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_status      (rsp_status),
      .rsp_live_count  (rsp_live_count)
   );

endmodule
